@@ src/rfrf_pkg.sv @@
package rfrf_pkg;

    localparam int MAX_FRAME   = 64;
    localparam int MIN_FRAME   = 14;
    localparam int HDR_LEN     = 13;
    localparam int PAYLOAD_MAX = MAX_FRAME - MIN_FRAME;

    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 7;
    localparam int PLEN_W  = 6;
    localparam int PADDR_W = $clog2(PAYLOAD_MAX);
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_DATA_W = 48;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OWN_ADDRESS       = 3'd0,
        REG_OWN_NET_ID        = 3'd1,
        REG_OWN_AREA_ID       = 3'd2,
        REG_BROADCAST_ADDRESS = 3'd3,
        REG_BROADCAST_NET_ID  = 3'd4,
        REG_BROADCAST_AREA_ID = 3'd5
    } cfg_reg_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_ACCEPTED  = 3'd0,
        ST_BAD_CKS   = 3'd1,
        ST_BAD_AREA  = 3'd2,
        ST_BAD_NET   = 3'd3,
        ST_DUPLICATE = 3'd4,
        ST_BAD_ADDR  = 3'd5,
        ST_MALFORMED = 3'd6
    } status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;         // input byte transfer this cycle
        logic load_single;  // load one status result into the output register
        logic emit_start;   // begin payload readout
        logic emit_step;    // load the next payload byte into the output register
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;     // output register can take a result this cycle
        logic start_bad;    // current byte is a frame start with bad length
        logic judge_byte;   // current byte is the checksum byte of an open frame
        logic judge_emit;   // frame is accepted and carries payload
        logic emit_last;    // payload byte being loaded is the final one
    } sts_t;

endpackage

@@ src/rfrf_ram.sv @@
module rfrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 50
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/rfrf_dp.sv @@
module rfrf_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [rfrf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rfrf_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic [rfrf_pkg::BYTE_W-1:0]        rx_byte,
    input  logic                               frame_start,
    input  rfrf_pkg::cmd_t                     cmd,
    output rfrf_pkg::sts_t                     sts,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic [rfrf_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic [2:0]                         m_tuser,
    output logic                               m_tlast
);

    // Configuration
    logic [15:0] own_address_reg, own_net_id_reg, bc_address_reg, bc_net_id_reg;
    logic [31:0] own_area_id_reg, bc_area_id_reg;

    // Frame parse state
    logic [rfrf_pkg::CNT_W-1:0]  byte_count_reg, frame_length_reg;
    logic [rfrf_pkg::BYTE_W-1:0] running_sum_reg;
    logic                        discarding_reg;
    logic [31:0] hdr_area_reg;
    logic [15:0] hdr_net_reg, hdr_dst_reg, hdr_src_reg;
    logic [7:0]  hdr_trans_reg, hdr_type_reg;
    logic [15:0] prev_dst_reg, prev_src_reg;
    logic [7:0]  prev_trans_reg, prev_type_reg;

    // Readout
    logic [rfrf_pkg::PADDR_W-1:0] emit_idx_reg;
    logic [rfrf_pkg::PLEN_W-1:0]  plen_reg;

    // Output register
    logic                         out_valid_reg;
    logic [2:0]                   out_status_reg;
    logic [15:0]                  out_src_reg;
    logic [7:0]                   out_trans_reg, out_type_reg;
    logic [rfrf_pkg::PLEN_W-1:0]  out_plen_reg;
    logic [7:0]                   out_byte_reg;
    logic                         out_last_reg;

    logic                         start_bad, judge_byte, judge_emit, hdr_pass, is_new;
    logic [rfrf_pkg::CNT_W:0]     idx_plus1;
    logic [rfrf_pkg::CNT_W-1:0]   plen_full;
    logic [rfrf_pkg::CNT_W-1:0]   pay_off;
    rfrf_pkg::status_t            judged;
    logic                         ram_wr_en, ram_rd_en;
    logic [rfrf_pkg::PADDR_W-1:0] ram_rd_addr;
    logic [7:0]                   ram_rd_data;
    logic [rfrf_pkg::PADDR_W-1:0] emit_idx_next;

    assign start_bad = frame_start &&
                       ((rx_byte < 8'(rfrf_pkg::MIN_FRAME)) ||
                        (rx_byte > 8'(rfrf_pkg::MAX_FRAME)));
    assign idx_plus1  = {1'b0, byte_count_reg} + 8'd1;
    assign judge_byte = !frame_start && !discarding_reg &&
                        (idx_plus1 >= {1'b0, frame_length_reg});
    assign plen_full  = frame_length_reg - 7'(rfrf_pkg::MIN_FRAME);
    assign pay_off    = byte_count_reg - 7'(rfrf_pkg::HDR_LEN);

    assign is_new = (prev_dst_reg != hdr_dst_reg) || (prev_src_reg != hdr_src_reg) ||
                    (prev_trans_reg != hdr_trans_reg) || (prev_type_reg != hdr_type_reg);

    // Judge in priority order
    always_comb begin
        hdr_pass = 1'b0;
        if (rx_byte != running_sum_reg) begin
            judged = rfrf_pkg::ST_BAD_CKS;
        end else if (hdr_area_reg != own_area_id_reg && hdr_area_reg != bc_area_id_reg) begin
            judged = rfrf_pkg::ST_BAD_AREA;
        end else if (hdr_net_reg != own_net_id_reg && hdr_net_reg != bc_net_id_reg) begin
            judged = rfrf_pkg::ST_BAD_NET;
        end else begin
            hdr_pass = 1'b1;
            if (!is_new) begin
                judged = rfrf_pkg::ST_DUPLICATE;
            end else if (hdr_dst_reg != own_address_reg && hdr_dst_reg != bc_address_reg) begin
                judged = rfrf_pkg::ST_BAD_ADDR;
            end else begin
                judged = rfrf_pkg::ST_ACCEPTED;
            end
        end
    end

    assign judge_emit = judge_byte && (judged == rfrf_pkg::ST_ACCEPTED) && (plen_full != '0);

    assign sts.out_free   = !out_valid_reg || m_tready;
    assign sts.start_bad  = start_bad;
    assign sts.judge_byte = judge_byte;
    assign sts.judge_emit = judge_emit;
    assign sts.emit_last  = ({1'b0, emit_idx_reg} + 7'd1) == {1'b0, plen_reg};

    // Config writes; indexes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_address_reg <= '0;
            own_net_id_reg  <= '0;
            own_area_id_reg <= '0;
            bc_address_reg  <= '1;
            bc_net_id_reg   <= '1;
            bc_area_id_reg  <= '1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rfrf_pkg::REG_OWN_ADDRESS:       own_address_reg <= cfg_wdata[15:0];
                rfrf_pkg::REG_OWN_NET_ID:        own_net_id_reg  <= cfg_wdata[15:0];
                rfrf_pkg::REG_OWN_AREA_ID:       own_area_id_reg <= cfg_wdata;
                rfrf_pkg::REG_BROADCAST_ADDRESS: bc_address_reg  <= cfg_wdata[15:0];
                rfrf_pkg::REG_BROADCAST_NET_ID:  bc_net_id_reg   <= cfg_wdata[15:0];
                rfrf_pkg::REG_BROADCAST_AREA_ID: bc_area_id_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Frame parsing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg   <= '0;
            frame_length_reg <= '0;
            running_sum_reg  <= '0;
            discarding_reg   <= 1'b1;
            hdr_area_reg     <= '0;
            hdr_net_reg      <= '0;
            hdr_dst_reg      <= '0;
            hdr_src_reg      <= '0;
            hdr_trans_reg    <= '0;
            hdr_type_reg     <= '0;
            prev_dst_reg     <= '0;
            prev_src_reg     <= '0;
            prev_trans_reg   <= '0;
            prev_type_reg    <= '0;
        end else if (cmd.take) begin
            if (frame_start) begin
                if (start_bad) begin
                    discarding_reg <= 1'b1;
                end else begin
                    discarding_reg   <= 1'b0;
                    frame_length_reg <= rx_byte[rfrf_pkg::CNT_W-1:0];
                    running_sum_reg  <= rx_byte;
                    byte_count_reg   <= 7'd1;
                    hdr_area_reg     <= '0;
                    hdr_net_reg      <= '0;
                    hdr_dst_reg      <= '0;
                    hdr_src_reg      <= '0;
                    hdr_trans_reg    <= '0;
                    hdr_type_reg     <= '0;
                end
            end else if (!discarding_reg) begin
                if (judge_byte) begin
                    discarding_reg <= 1'b1;
                    // Any difference makes the frame new: overwrite the record
                    if (hdr_pass && is_new) begin
                        prev_dst_reg   <= hdr_dst_reg;
                        prev_src_reg   <= hdr_src_reg;
                        prev_trans_reg <= hdr_trans_reg;
                        prev_type_reg  <= hdr_type_reg;
                    end
                end else begin
                    running_sum_reg <= running_sum_reg + rx_byte;
                    byte_count_reg  <= idx_plus1[rfrf_pkg::CNT_W-1:0];
                    if (byte_count_reg <= 7'd4) begin
                        hdr_area_reg <= {hdr_area_reg[23:0], rx_byte};
                    end else if (byte_count_reg <= 7'd6) begin
                        hdr_net_reg <= {hdr_net_reg[7:0], rx_byte};
                    end else if (byte_count_reg <= 7'd8) begin
                        hdr_dst_reg <= {hdr_dst_reg[7:0], rx_byte};
                    end else if (byte_count_reg <= 7'd10) begin
                        hdr_src_reg <= {hdr_src_reg[7:0], rx_byte};
                    end else if (byte_count_reg == 7'd11) begin
                        hdr_trans_reg <= rx_byte;
                    end else if (byte_count_reg == 7'd12) begin
                        hdr_type_reg <= rx_byte;
                    end
                end
            end
        end
    end

    assign ram_wr_en = cmd.take && !frame_start && !discarding_reg && !judge_byte &&
                       (byte_count_reg >= 7'(rfrf_pkg::HDR_LEN)) &&
                       (pay_off < 7'(rfrf_pkg::PAYLOAD_MAX));

    assign emit_idx_next = emit_idx_reg + 6'd1;
    assign ram_rd_en     = cmd.emit_start || (cmd.emit_step && !sts.emit_last);
    assign ram_rd_addr   = cmd.emit_start ? '0 : emit_idx_next;

    rfrf_ram #(
        .WIDTH (rfrf_pkg::BYTE_W),
        .DEPTH (rfrf_pkg::PAYLOAD_MAX)
    ) u_payload_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (pay_off[rfrf_pkg::PADDR_W-1:0]),
        .wr_data (rx_byte),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (cmd.emit_start) begin
            emit_idx_reg <= '0;
            plen_reg     <= plen_full[rfrf_pkg::PLEN_W-1:0];
        end else if (cmd.emit_step) begin
            emit_idx_reg <= emit_idx_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_single || cmd.emit_step) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_single) begin
            out_plen_reg <= '0;
            out_byte_reg <= '0;
            out_last_reg <= 1'b1;
            if (start_bad) begin
                out_status_reg <= rfrf_pkg::ST_MALFORMED;
                out_src_reg    <= '0;
                out_trans_reg  <= '0;
                out_type_reg   <= '0;
            end else begin
                out_status_reg <= judged;
                out_src_reg    <= hdr_src_reg;
                out_trans_reg  <= hdr_trans_reg;
                out_type_reg   <= hdr_type_reg;
            end
        end else if (cmd.emit_step) begin
            out_status_reg <= rfrf_pkg::ST_ACCEPTED;
            out_src_reg    <= hdr_src_reg;
            out_trans_reg  <= hdr_trans_reg;
            out_type_reg   <= hdr_type_reg;
            out_plen_reg   <= plen_reg;
            out_byte_reg   <= ram_rd_data;
            out_last_reg   <= sts.emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_byte_reg, out_plen_reg, out_type_reg,
                       out_trans_reg, out_src_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ src/rfrf_ctrl.sv @@
module rfrf_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  rfrf_pkg::sts_t sts,
    output rfrf_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_RX   = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_RX) && sts.out_free;

    always_comb begin
        state_next      = state_reg;
        cmd.take        = 1'b0;
        cmd.load_single = 1'b0;
        cmd.emit_start  = 1'b0;
        cmd.emit_step   = 1'b0;
        unique case (state_reg)
            ST_RX: begin
                if (s_tvalid && s_tready) begin
                    cmd.take = 1'b1;
                    if (sts.start_bad) begin
                        cmd.load_single = 1'b1;
                    end else if (sts.judge_byte) begin
                        if (sts.judge_emit) begin
                            cmd.emit_start = 1'b1;
                            state_next     = ST_EMIT;
                        end else begin
                            cmd.load_single = 1'b1;
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit_step = 1'b1;
                    if (sts.emit_last) begin
                        state_next = ST_RX;
                    end
                end
            end
            default: state_next = ST_RX;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RX;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/radio_frame_receive_filter.sv @@
// Radio link frame receive filter.
// Input stream: one received byte per transfer on s_tdata, with s_tuser high
// on the length byte that opens a frame. Bytes outside an open frame are
// dropped silently; a new frame start abandons an unfinished frame.
// On the checksum byte the frame is judged (checksum, area id, net id,
// duplicate record, destination address). A rejection or a bad length gives
// one status transfer on the m_ channel; an accepted frame gives one transfer
// per payload byte (or one empty transfer for a payload of zero bytes), with
// m_tlast on the final transfer of the frame.
// Throughput: one input byte per cycle while receiving and the output register
// is free. Payload bytes are held in a single-port-read RAM and stream out one
// per cycle, while the receiver takes them, once the frame is accepted; input
// is held off during that readout. A status result is registered in the output
// register and valid in the cycle after the deciding byte transfer; the first
// payload byte passes through the RAM read register, then the output register.
// Reset clears the parser to "no frame open", the duplicate record to zero and
// the configuration registers to their defaults. A stalled receiver holds the
// output register; input and readout pause until it is taken.
module radio_frame_receive_filter (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port
    input  logic                                cfg_wr_en,
    input  logic [rfrf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rfrf_pkg::CFG_W-1:0]          cfg_wdata,
    // Input byte stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] rx_byte
    input  logic                                s_tuser,   // [0] frame_start
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [15:0] src_addr, [23:16] trans_id, [31:24] pkt_type,
    // [37:32] payload_length, [45:38] payload_byte, [47:46] zero
    output logic [rfrf_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [2:0]                          m_tuser,   // [2:0] status
    output logic                                m_tlast    // last
);

    rfrf_pkg::cmd_t cmd;
    rfrf_pkg::sts_t sts;

    // Sequence the byte intake and the payload readout
    rfrf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Parse the header, buffer payload, judge the frame, hold the result
    rfrf_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .rx_byte     (s_tdata),
        .frame_start (s_tuser),
        .cmd         (cmd),
        .sts         (sts),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

@@ verif/tb.sv @@
module tb;

    // Cycles in a row with no transfer on either channel before the run is abandoned
    localparam int QUIET_LIMIT = 2000;

    typedef enum {K_FRAME, K_STRAY} row_kind_t;
    typedef enum {RX_OPEN, RX_LIGHT, RX_SPARSE, RX_COIN} stall_mode_t;

    // One stimulus row: a frame (possibly malformed or cut short) or a run of stray bytes
    typedef struct {
        row_kind_t         kind;
        int                len;       // length byte; byte count for a stray run
        logic [31:0]       area;
        logic [15:0]       net;
        logic [15:0]       dst;
        logic [15:0]       src;
        logic [7:0]        trans;
        logic [7:0]        ptype;
        int                pfill;     // payload byte value, or -1 for random payload
        bit                cks_bad;   // corrupt the checksum byte
        int                cut;       // body bytes sent before the next frame start; 0 = whole
        bit                typed;     // verdict is written into the row
        rfrf_pkg::status_t exp_st;
    } frame_t;

    // One result transfer as seen on the m_ channel
    typedef struct {
        rfrf_pkg::status_t st;
        logic [15:0]       src;
        logic [7:0]        trans;
        logic [7:0]        ptype;
        logic [5:0]        plen;
        logic [7:0]        pbyte;
        logic              eof;
    } frame_res_t;

    logic                            aclk;
    logic                            aresetn = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [rfrf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rfrf_pkg::CFG_W-1:0]      cfg_wdata = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata = 8'h00;
    logic                            s_tuser = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [rfrf_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [2:0]                      m_tuser;
    logic                            m_tlast;

    radio_frame_receive_filter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // ---------------------------------------------------------------------
    // Filter predictor: configuration copy, parser state and duplicate record
    // ---------------------------------------------------------------------
    logic [15:0] own_addr = 16'h0000;
    logic [15:0] own_net  = 16'h0000;
    logic [31:0] own_area = 32'h0000_0000;
    logic [15:0] bc_addr  = 16'hFFFF;
    logic [15:0] bc_net   = 16'hFFFF;
    logic [31:0] bc_area  = 32'hFFFF_FFFF;

    int          frm_len  = 0;
    int          pos      = 0;
    logic [7:0]  cks_sum  = 8'h00;
    bit          skipping = 1'b1;       // no frame open after reset
    logic [31:0] rx_area  = '0;
    logic [15:0] rx_net   = '0;
    logic [15:0] rx_dst   = '0;
    logic [15:0] rx_src   = '0;
    logic [7:0]  rx_trans = '0;
    logic [7:0]  rx_ptype = '0;
    logic [7:0]  pay_buf [rfrf_pkg::PAYLOAD_MAX];
    logic [15:0] seen_dst   = '0;
    logic [15:0] seen_src   = '0;
    logic [7:0]  seen_trans = '0;
    logic [7:0]  seen_ptype = '0;

    frame_res_t  byte_results [$];      // results caused by the byte just taken
    frame_res_t  results_due [$];       // results still owed by the block
    bit          byte_ignored;

    // Header of the last frame sent, reused to provoke duplicates
    logic [15:0] prior_dst = '0;
    logic [15:0] prior_src = '0;
    logic [7:0]  prior_trans = '0;
    logic [7:0]  prior_ptype = '0;

    int          errors = 0;
    int          live_bytes = 0;        // bytes the filter acted on
    int          burst_left = 0;
    bit          steady = 1'b0;         // sender runs without gaps
    stall_mode_t stall_mode = RX_OPEN;
    int          stall_tick = 0;
    int          quiet = 0;

    function automatic void push_result(rfrf_pkg::status_t st, logic [15:0] src,
                                        logic [7:0] trans, logic [7:0] ptype,
                                        logic [5:0] plen, logic [7:0] pbyte, logic eof);
        frame_res_t r;
        r.st = st;
        r.src = src;
        r.trans = trans;
        r.ptype = ptype;
        r.plen = plen;
        r.pbyte = pbyte;
        r.eof = eof;
        byte_results.push_back(r);
    endfunction

    // Advance the predictor by one received byte
    function automatic void filter_byte(logic [7:0] b, logic fs);
        rfrf_pkg::status_t st;
        int                bv;
        int                plen;
        int                k;
        bv = int'(b);
        byte_ignored = 1'b0;
        if (fs) begin
            // A bad length closes the frame at once with a single status transfer
            if (bv < rfrf_pkg::MIN_FRAME || bv > rfrf_pkg::MAX_FRAME) begin
                skipping = 1'b1;
                push_result(rfrf_pkg::ST_MALFORMED, 16'h0, 8'h0, 8'h0, 6'd0, 8'h0, 1'b1);
            end else begin
                // Open a new frame; an unfinished one is dropped without a word
                skipping = 1'b0;
                frm_len = bv;
                cks_sum = b;
                pos = 1;
                rx_area = '0;
                rx_net = '0;
                rx_dst = '0;
                rx_src = '0;
                rx_trans = '0;
                rx_ptype = '0;
            end
        end else if (skipping) begin
            byte_ignored = 1'b1;
        end else if (pos + 1 >= frm_len) begin
            // Checksum byte: judge in the fixed order
            skipping = 1'b1;
            st = rfrf_pkg::ST_ACCEPTED;
            if (b != cks_sum) begin
                st = rfrf_pkg::ST_BAD_CKS;
            end else if (rx_area != own_area && rx_area != bc_area) begin
                st = rfrf_pkg::ST_BAD_AREA;
            end else if (rx_net != own_net && rx_net != bc_net) begin
                st = rfrf_pkg::ST_BAD_NET;
            end else if (seen_dst != rx_dst || seen_src != rx_src ||
                         seen_trans != rx_trans || seen_ptype != rx_ptype) begin
                // New header: record it even when the address then rejects it
                seen_dst = rx_dst;
                seen_src = rx_src;
                seen_trans = rx_trans;
                seen_ptype = rx_ptype;
                if (rx_dst != own_addr && rx_dst != bc_addr)
                    st = rfrf_pkg::ST_BAD_ADDR;
            end else begin
                st = rfrf_pkg::ST_DUPLICATE;
            end
            plen = frm_len - rfrf_pkg::MIN_FRAME;
            if (st != rfrf_pkg::ST_ACCEPTED || plen == 0) begin
                push_result(st, rx_src, rx_trans, rx_ptype, 6'd0, 8'h00, 1'b1);
            end else begin
                for (k = 0; k < plen; k++)
                    push_result(rfrf_pkg::ST_ACCEPTED, rx_src, rx_trans, rx_ptype, 6'(plen),
                                pay_buf[k], k == plen - 1);
            end
        end else begin
            cks_sum = cks_sum + b;
            if (pos <= 4)
                rx_area = {rx_area[23:0], b};
            else if (pos <= 6)
                rx_net = {rx_net[7:0], b};
            else if (pos <= 8)
                rx_dst = {rx_dst[7:0], b};
            else if (pos <= 10)
                rx_src = {rx_src[7:0], b};
            else if (pos == 11)
                rx_trans = b;
            else if (pos == 12)
                rx_ptype = b;
            else if (pos - rfrf_pkg::HDR_LEN < rfrf_pkg::PAYLOAD_MAX)
                pay_buf[pos - rfrf_pkg::HDR_LEN] = b;
            pos = pos + 1;
        end
    endfunction

    function automatic frame_t mk(row_kind_t kind, int len, logic [31:0] area,
                                  logic [15:0] net, logic [15:0] dst, logic [15:0] src,
                                  logic [7:0] trans, logic [7:0] ptype, int pfill,
                                  bit cks_bad, int cut, bit typed,
                                  rfrf_pkg::status_t exp_st);
        frame_t f;
        f.kind = kind;
        f.len = len;
        f.area = area;
        f.net = net;
        f.dst = dst;
        f.src = src;
        f.trans = trans;
        f.ptype = ptype;
        f.pfill = pfill;
        f.cks_bad = cks_bad;
        f.cut = cut;
        f.typed = typed;
        f.exp_st = exp_st;
        return f;
    endfunction

    // Random frame, mostly well formed and addressed to this node
    function automatic frame_t rand_frame();
        frame_t f;
        int     r;
        f = mk(K_FRAME, int'($urandom_range(14, 22)), own_area, own_net, own_addr,
               16'($urandom), 8'($urandom), 8'($urandom), -1, 1'b0, 0, 1'b0,
               rfrf_pkg::ST_ACCEPTED);
        r = int'($urandom_range(0, 99));
        if (r < 6) begin
            f.len = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 13))
                                                : int'($urandom_range(65, 255));
            f.cut = int'($urandom_range(0, 6));
        end else if (r < 8) begin
            f.len = rfrf_pkg::MAX_FRAME;
        end else if (r < 18) begin
            f.len = int'($urandom_range(23, 64));
        end
        case ($urandom_range(0, 9))
            0: f.area = $urandom;
            1, 2, 3, 4: f.area = own_area;
            default: f.area = bc_area;
        endcase
        case ($urandom_range(0, 9))
            0: f.net = 16'($urandom);
            1, 2, 3, 4: f.net = own_net;
            default: f.net = bc_net;
        endcase
        case ($urandom_range(0, 9))
            0, 1: f.dst = 16'($urandom);
            2, 3, 4, 5: f.dst = own_addr;
            default: f.dst = bc_addr;
        endcase
        // Repeat the last header now and then to hit the duplicate test
        if ($urandom_range(0, 4) == 0) begin
            f.dst = prior_dst;
            f.src = prior_src;
            f.trans = prior_trans;
            f.ptype = prior_ptype;
        end
        if ($urandom_range(0, 11) == 0)
            f.cks_bad = 1'b1;
        // Cut a well-formed frame short so the next start abandons it
        if (f.len >= rfrf_pkg::MIN_FRAME && f.len <= rfrf_pkg::MAX_FRAME &&
            $urandom_range(0, 15) == 0)
            f.cut = int'($urandom_range(1, f.len - 2));
        return f;
    endfunction

    // ---------------------------------------------------------------------
    // Clock, input side and configuration
    // ---------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Offer one byte in bursts with random gaps; record what it owes on transfer.
    // Entered and left at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic fs, input bit use_typed,
                             input frame_res_t verdict);
        int gap;
        begin
            if (!steady && burst_left == 0) begin
                burst_left = int'($urandom_range(1, 24));
                gap = int'($urandom_range(1, 6));
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            if (burst_left > 0)
                burst_left--;
            s_tvalid = 1'b1;
            s_tdata = b;
            s_tuser = fs;
            @(posedge aclk);
            while (!s_tready)
                @(posedge aclk);
            // Transfer done at this edge: queue what the byte causes
            byte_results.delete();
            filter_byte(b, fs);
            if (use_typed) begin
                results_due.push_back(verdict);
            end else begin
                foreach (byte_results[n])
                    results_due.push_back(byte_results[n]);
            end
            if (!byte_ignored)
                live_bytes++;
            @(negedge aclk);
        end
    endtask

    task automatic send_frame(input frame_t f);
        logic [7:0] fb [0:63];
        logic [7:0] sum;
        frame_res_t verdict;
        int         lf;
        int         total;
        int         decide;
        int         i;
        bit         bad;
        begin
            verdict.st = f.exp_st;
            verdict.plen = 6'd0;
            verdict.pbyte = 8'h00;
            verdict.eof = 1'b1;
            if (f.kind == K_STRAY) begin
                for (i = 0; i < f.len; i++)
                    send_byte(8'($urandom), 1'b0, 1'b0, verdict);
            end else begin
                bad = f.len < rfrf_pkg::MIN_FRAME || f.len > rfrf_pkg::MAX_FRAME;
                // A malformed frame sends at most a short tail, so a minimal body will do
                lf = bad ? rfrf_pkg::MIN_FRAME : f.len;
                fb[0] = 8'(f.len);
                {fb[1], fb[2], fb[3], fb[4]} = f.area;
                {fb[5], fb[6]} = f.net;
                {fb[7], fb[8]} = f.dst;
                {fb[9], fb[10]} = f.src;
                fb[11] = f.trans;
                fb[12] = f.ptype;
                for (i = rfrf_pkg::HDR_LEN; i < lf - 1; i++)
                    fb[i] = (f.pfill < 0) ? 8'($urandom) : 8'(f.pfill);
                sum = 8'h00;
                for (i = 0; i < lf - 1; i++)
                    sum = sum + fb[i];
                fb[lf - 1] = f.cks_bad ? sum ^ 8'($urandom_range(1, 255)) : sum;
                total = (f.cut > 0) ? f.cut + 1 : (bad ? 1 : lf);
                decide = bad ? 0 : ((f.cut > 0) ? -1 : lf - 1);
                verdict.src = bad ? 16'h0000 : f.src;
                verdict.trans = bad ? 8'h00 : f.trans;
                verdict.ptype = bad ? 8'h00 : f.ptype;
                for (i = 0; i < total; i++)
                    send_byte(fb[i], i == 0, f.typed && i == decide, verdict);
                prior_dst = f.dst;
                prior_src = f.src;
                prior_trans = f.trans;
                prior_ptype = f.ptype;
            end
        end
    endtask

    // Hold the input until every owed result is out, then let the pipe settle
    task automatic drain();
        begin
            s_tvalid = 1'b0;
            while (results_due.size() != 0)
                @(negedge aclk);
            repeat (4) @(negedge aclk);
        end
    endtask

    task automatic write_reg(input rfrf_pkg::cfg_reg_t idx, input logic [31:0] v);
        begin
            cfg_wr_en = 1'b1;
            cfg_index = idx;
            cfg_wdata = v;
            @(negedge aclk);
            cfg_wr_en = 1'b0;
            case (idx)
                rfrf_pkg::REG_OWN_ADDRESS:       own_addr = v[15:0];
                rfrf_pkg::REG_OWN_NET_ID:        own_net = v[15:0];
                rfrf_pkg::REG_OWN_AREA_ID:       own_area = v;
                rfrf_pkg::REG_BROADCAST_ADDRESS: bc_addr = v[15:0];
                rfrf_pkg::REG_BROADCAST_NET_ID:  bc_net = v[15:0];
                rfrf_pkg::REG_BROADCAST_AREA_ID: bc_area = v;
                default: ;
            endcase
        end
    endtask

    // ---------------------------------------------------------------------
    // Result side: receiver stalls on its own pattern, checker pops in order
    // ---------------------------------------------------------------------
    always @(negedge aclk) begin
        // Switch stall pattern on stall_tick; the open pattern gives stall-free stretches
        if (stall_tick % 80 == 0)
            stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_tick++;
        case (stall_mode)
            RX_OPEN:   m_tready = 1'b1;
            RX_LIGHT:  m_tready = ($urandom_range(0, 3) != 0);
            RX_SPARSE: m_tready = (stall_tick % 5 == 0);
            default:   m_tready = ($urandom_range(0, 1) == 1);
        endcase
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        frame_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transfer, expected none, actual %h/%h/%b",
                         $time, m_tuser, m_tdata, m_tlast);
            end else begin
                want = results_due.pop_front();
                check_field("status", 32'(want.st), 32'(m_tuser));
                check_field("src_addr", 32'(want.src), 32'(m_tdata[15:0]));
                check_field("trans_id", 32'(want.trans), 32'(m_tdata[23:16]));
                check_field("pkt_type", 32'(want.ptype), 32'(m_tdata[31:24]));
                check_field("payload_length", 32'(want.plen), 32'(m_tdata[37:32]));
                check_field("payload_byte", 32'(want.pbyte), 32'(m_tdata[45:38]));
                check_field("tdata pad", 32'h0, 32'(m_tdata[47:46]));
                check_field("last", 32'(want.eof), 32'(m_tlast));
            end
        end
    end

    // Abandon the run after a long stretch with no transfer on either side
    initial begin
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    initial begin
        frame_t      plan [$];
        logic [31:0] cfg_set [6];
        int          ph;
        int          i;
        int          goal;

        // Directed rows, run with the reset configuration:
        // own address/net/area 0, broadcast all ones
        plan.push_back(mk(K_STRAY, 20, 32'h0, 16'h0, 16'h0, 16'h0, 8'h0, 8'h0,
                          -1, 1'b0, 0, 1'b0, rfrf_pkg::ST_ACCEPTED)); // bytes before any frame
        plan.push_back(mk(K_FRAME, 14, 32'h0, 16'h0, 16'h0, 16'h0001, 8'h00, 8'h00,
                          -1, 1'b0, 0, 1'b1, rfrf_pkg::ST_ACCEPTED)); // empty payload
        plan.push_back(mk(K_FRAME, 14, 32'h0, 16'h0, 16'h0, 16'h0001, 8'h00, 8'h00,
                          -1, 1'b0, 0, 1'b1, rfrf_pkg::ST_DUPLICATE)); // same header again
        plan.push_back(mk(K_FRAME, 64, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          8'hFF, 8'hFF, 255, 1'b0, 0, 1'b0,
                          rfrf_pkg::ST_ACCEPTED));                    // longest frame
        plan.push_back(mk(K_FRAME, 13, 32'h0, 16'h0, 16'h0, 16'h0, 8'h0, 8'h0,
                          -1, 1'b0, 5, 1'b1, rfrf_pkg::ST_MALFORMED)); // one below minimum
        plan.push_back(mk(K_FRAME, 65, 32'h0, 16'h0, 16'h0, 16'h0, 8'h0, 8'h0,
                          -1, 1'b0, 3, 1'b1, rfrf_pkg::ST_MALFORMED)); // one above maximum
        plan.push_back(mk(K_FRAME, 0, 32'h0, 16'h0, 16'h0, 16'h0, 8'h0, 8'h0,
                          -1, 1'b0, 0, 1'b1, rfrf_pkg::ST_MALFORMED));
        plan.push_back(mk(K_FRAME, 255, 32'h0, 16'h0, 16'h0, 16'h0, 8'h0, 8'h0,
                          -1, 1'b0, 2, 1'b1, rfrf_pkg::ST_MALFORMED));
        plan.push_back(mk(K_FRAME, 20, 32'h0, 16'h0, 16'h0, 16'h1234, 8'h07, 8'h03,
                          -1, 1'b1, 0, 1'b1, rfrf_pkg::ST_BAD_CKS));
        plan.push_back(mk(K_FRAME, 16, 32'h0000_0001, 16'h0, 16'h0, 16'h2222, 8'h11, 8'h22,
                          -1, 1'b0, 0, 1'b1, rfrf_pkg::ST_BAD_AREA));
        plan.push_back(mk(K_FRAME, 16, 32'h0, 16'h0001, 16'h0, 16'h3333, 8'h33, 8'h44,
                          -1, 1'b0, 0, 1'b1, rfrf_pkg::ST_BAD_NET));
        plan.push_back(mk(K_FRAME, 18, 32'hFFFF_FFFF, 16'hFFFF, 16'h0002, 16'h00AA,
                          8'h10, 8'h20, -1, 1'b0, 0, 1'b1, rfrf_pkg::ST_BAD_ADDR));
        // The address reject above still updated the duplicate record
        plan.push_back(mk(K_FRAME, 18, 32'hFFFF_FFFF, 16'hFFFF, 16'h0002, 16'h00AA,
                          8'h10, 8'h20, -1, 1'b0, 0, 1'b1, rfrf_pkg::ST_DUPLICATE));
        plan.push_back(mk(K_FRAME, 30, 32'h0, 16'h0, 16'h0, 16'h4444, 8'h55, 8'h66,
                          -1, 1'b0, 10, 1'b0, rfrf_pkg::ST_ACCEPTED)); // restart mid-frame
        plan.push_back(mk(K_FRAME, 15, 32'h0, 16'h0, 16'h0, 16'h8000, 8'h80, 8'h01,
                          0, 1'b0, 0, 1'b0,
                          rfrf_pkg::ST_ACCEPTED));            // single zero payload byte
        plan.push_back(mk(K_FRAME, 14, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, 16'h7FFF, 8'h01, 8'h80,
                          -1, 1'b0, 0, 1'b1,
                          rfrf_pkg::ST_ACCEPTED));            // all-broadcast but net
        plan.push_back(mk(K_STRAY, 5, 32'h0, 16'h0, 16'h0, 16'h0, 8'h0, 8'h0,
                          -1, 1'b0, 0, 1'b0,
                          rfrf_pkg::ST_ACCEPTED));            // bytes after a closed frame
        plan.push_back(mk(K_FRAME, 40, 32'h0, 16'hFFFF, 16'h0, 16'h5A5A, 8'hA5, 8'h5A,
                          -1, 1'b0, 0, 1'b0, rfrf_pkg::ST_ACCEPTED));
        plan.push_back(mk(K_FRAME, 20, 32'h0, 16'h0, 16'h0, 16'h0F0F, 8'h0F, 8'hF0,
                          -1, 1'b0, 18, 1'b0,
                          rfrf_pkg::ST_ACCEPTED));            // checksum byte missing
        plan.push_back(mk(K_FRAME, 14, 32'h0, 16'h0, 16'h0, 16'hF0F0, 8'h3C, 8'hC3,
                          -1, 1'b1, 0, 1'b1, rfrf_pkg::ST_BAD_CKS));

        // Hold reset, then release it on a falling edge
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (plan[n])
            send_frame(plan[n]);

        // Random phases, each under a fresh register setting
        for (ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0: cfg_set = '{32'h0000_1234, 32'h0000_00A5, 32'hDEAD_BEEF,
                               32'h0000_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF};
                1: cfg_set = '{32'h0000_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF,
                               32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
                2: for (i = 0; i < 6; i++)
                       cfg_set[i] = $urandom;
                default: cfg_set = '{32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000,
                                     32'h0001_FFFF, 32'h0000_FFFF, 32'h8000_0001};
            endcase
            for (i = 0; i < 6; i++)
                write_reg(rfrf_pkg::cfg_reg_t'(i), cfg_set[i]);
            goal = live_bytes + 15;
            while (live_bytes < goal) begin
                if ($urandom_range(0, 5) == 0)
                    steady = !steady;
                send_frame(rand_frame());
                if ($urandom_range(0, 9) == 0)
                    send_frame(mk(K_STRAY, int'($urandom_range(1, 4)), 32'h0, 16'h0, 16'h0,
                                  16'h0, 8'h0, 8'h0, -1, 1'b0, 0, 1'b0,
                                  rfrf_pkg::ST_ACCEPTED));
                // Pause the sender now and then until the block has caught up
                if ($urandom_range(0, 29) == 0)
                    drain();
            end
        end

        drain();
        repeat (8) @(negedge aclk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
